>>> rtl/imft_pkg.sv
// Shared types and constants for the IPv4 mask filter table.
`default_nettype none

package imft_pkg;

    localparam int MAX_FILTERS = 1024;
    localparam int IDX_W       = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int CNT_W       = $clog2(MAX_FILTERS + 1);
    localparam int SLOT_W      = 10;
    localparam int ADDR_W      = 32;

    localparam logic [ADDR_W-1:0] FREED_VALUE = 32'hffff_ffff;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

>>> rtl/ipv4_mask_filter_table_top.sv
// Top level of the IPv4 mask/compare filter table with its scan sequencer.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one command beat: s_mode selects
//   lookup (s_address), add or remove (s_rule_mask/s_rule_value). Result
//   channel (m_valid/m_ready) returns exactly one beat per command with
//   m_refuse, m_status and m_slot. cfg_wr_en/cfg_wr_data write the ban_mode
//   bit; write it only while no command is in flight.
//   Scan: the filter memory has one read port, so the scan reads one slot
//   per cycle. The registered read data is compared, and the scan stops at
//   the first match or once all used slots miss (at once on an empty table;
//   a full table holds 1024 slots). An unused mode skips the scan. The
//   result then waits in the response state and loads into the output register.
//   Flow: one command at a time; s_ready is high only while the sequencer
//   is idle, which begins as the result loads. A new command may be taken
//   while the previous result still waits in the output register.
//   Stall: when m_ready is low the result beat holds; a finished scan waits
//   in the response state until the output register frees.
//   Reset (aresetn low, synchronous): clears the used-slot count, sequencer
//   and output valid, sets ban_mode to 1; table contents are left as is.
`default_nettype none

module ipv4_mask_filter_table_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_wr_data,
    // command channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [31:0] s_address,
    input  wire logic [31:0] s_rule_mask,
    input  wire logic [31:0] s_rule_value,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_refuse,
    output logic [1:0]       m_status,
    output logic [9:0]       m_slot
);

    // Filter storage: one read and one write port, read data registered.
    logic [imft_pkg::ADDR_W-1:0] mask_mem  [imft_pkg::MAX_FILTERS];
    logic [imft_pkg::ADDR_W-1:0] value_mem [imft_pkg::MAX_FILTERS];

    imft_pkg::state_t state_reg, state_next;

    logic                          ban_mode_reg;
    logic [imft_pkg::CNT_W-1:0]    used_count_reg, used_count_next;

    // captured command
    logic [1:0]                    mode_reg;
    logic [imft_pkg::ADDR_W-1:0]   addr_reg;
    logic [imft_pkg::ADDR_W-1:0]   rmask_reg;
    logic [imft_pkg::ADDR_W-1:0]   rvalue_reg;

    // scan pipeline: read issue index, then the entry under test
    logic [imft_pkg::CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                          chk_vld_reg, chk_vld_next;
    logic [imft_pkg::IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [imft_pkg::ADDR_W-1:0]   rd_mask_reg;
    logic [imft_pkg::ADDR_W-1:0]   rd_value_reg;

    // pending result
    logic                          res_refuse_reg, res_refuse_next;
    logic [1:0]                    res_status_reg, res_status_next;
    logic [imft_pkg::SLOT_W-1:0]   res_slot_reg, res_slot_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic                          m_refuse_reg;
    logic [1:0]                    m_status_reg;
    logic [imft_pkg::SLOT_W-1:0]   m_slot_reg;

    logic                          accept;
    logic                          rd_en;
    logic                          wr_en;
    logic [imft_pkg::IDX_W-1:0]    wr_addr;
    logic [imft_pkg::ADDR_W-1:0]   wr_mask;
    logic [imft_pkg::ADDR_W-1:0]   wr_value;
    logic                          entry_match;
    logic                          hit;
    logic                          more_reads;
    logic                          scan_done;
    logic                          table_full;
    logic                          out_free;
    logic                          load_out;

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign more_reads = rd_idx_reg < used_count_reg;
    assign table_full = used_count_reg == imft_pkg::CNT_W'(imft_pkg::MAX_FILTERS);

    // Shared compare unit: one stored entry tested per cycle.
    always_comb begin
        case (mode_reg)
            imft_pkg::MODE_LOOKUP: entry_match = (addr_reg & rd_mask_reg) == rd_value_reg;
            imft_pkg::MODE_ADD:    entry_match = rd_value_reg == imft_pkg::FREED_VALUE;
            imft_pkg::MODE_REMOVE: entry_match = (rd_mask_reg == rmask_reg) &&
                                                 (rd_value_reg == rvalue_reg);
            default:               entry_match = 1'b0;
        endcase
    end

    assign hit = chk_vld_reg && entry_match;
    // Stop once a match shows up, or once every used slot has been checked.
    assign scan_done = hit || (!chk_vld_reg && !more_reads);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            imft_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_mode == imft_pkg::MODE_LOOKUP || s_mode == imft_pkg::MODE_ADD ||
                        s_mode == imft_pkg::MODE_REMOVE) begin
                        state_next = imft_pkg::ST_SCAN;
                    end else begin
                        state_next = imft_pkg::ST_RESP;
                    end
                end
            end
            imft_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = imft_pkg::ST_RESP;
                end
            end
            imft_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = imft_pkg::ST_IDLE;
                end
            end
            default: state_next = imft_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath control
    always_comb begin
        s_ready         = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = chk_idx_reg;
        wr_mask         = rmask_reg;
        wr_value        = rvalue_reg;
        used_count_next = used_count_reg;
        rd_idx_next     = rd_idx_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = rd_idx_reg[imft_pkg::IDX_W-1:0];
        res_refuse_next = res_refuse_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        load_out        = 1'b0;
        case (state_reg)
            imft_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                rd_idx_next = '0;
                // unused mode codes answer with all zeros
                res_refuse_next = 1'b0;
                res_status_next = imft_pkg::STAT_DONE;
                res_slot_next   = '0;
            end
            imft_pkg::ST_SCAN: begin
                rd_en        = !scan_done && more_reads;
                chk_vld_next = rd_en;
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + imft_pkg::CNT_W'(1);
                end
                if (scan_done) begin
                    res_refuse_next = 1'b0;
                    res_status_next = imft_pkg::STAT_DONE;
                    res_slot_next   = hit ? imft_pkg::SLOT_W'(chk_idx_reg) : '0;
                    case (mode_reg)
                        imft_pkg::MODE_LOOKUP: begin
                            res_refuse_next = hit ? ban_mode_reg : !ban_mode_reg;
                        end
                        imft_pkg::MODE_ADD: begin
                            if (hit) begin
                                wr_en = 1'b1;
                            end else if (table_full) begin
                                res_status_next = imft_pkg::STAT_FULL;
                            end else begin
                                // append behind the last used slot
                                wr_en           = 1'b1;
                                wr_addr         = used_count_reg[imft_pkg::IDX_W-1:0];
                                used_count_next = used_count_reg + imft_pkg::CNT_W'(1);
                                res_slot_next   = imft_pkg::SLOT_W'(
                                                  used_count_reg[imft_pkg::IDX_W-1:0]);
                            end
                        end
                        imft_pkg::MODE_REMOVE: begin
                            if (hit) begin
                                wr_en    = 1'b1;
                                wr_value = imft_pkg::FREED_VALUE;
                            end else begin
                                res_status_next = imft_pkg::STAT_NOT_FOUND;
                            end
                        end
                        default: res_status_next = imft_pkg::STAT_DONE;
                    endcase
                end
            end
            imft_pkg::ST_RESP: begin
                load_out = out_free;
            end
            default: s_ready = 1'b0;
        endcase
    end

    // Output register: load a finished result, drop valid when taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= imft_pkg::ST_IDLE;
            ban_mode_reg   <= 1'b1;
            used_count_reg <= '0;
            chk_vld_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            chk_vld_reg    <= chk_vld_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                ban_mode_reg <= cfg_wr_data[0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        chk_idx_reg    <= chk_idx_next;
        res_refuse_reg <= res_refuse_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (accept) begin
            mode_reg   <= s_mode;
            addr_reg   <= s_address;
            rmask_reg  <= s_rule_mask;
            rvalue_reg <= s_rule_value;
        end
        if (load_out) begin
            m_refuse_reg <= res_refuse_reg;
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
        end
    end

    // Filter memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mask_mem[wr_addr]  <= wr_mask;
            value_mem[wr_addr] <= wr_value;
        end
        if (rd_en) begin
            rd_mask_reg  <= mask_mem[rd_idx_reg[imft_pkg::IDX_W-1:0]];
            rd_value_reg <= value_mem[rd_idx_reg[imft_pkg::IDX_W-1:0]];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_refuse = m_refuse_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;

endmodule

`default_nettype wire

>>> rtl/imft_checker.sv
// Port-level checker for the filter table, bound to the top level.
`default_nettype none

module imft_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_refuse,
    input wire logic [1:0]  m_status,
    input wire logic [9:0]  m_slot
);

    // Busy after taking a command beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high right after a command beat");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot)
                                && $stable(m_refuse))
        else $error("stalled result beat changed");

    // Full and not-found answers name no slot and carry no refusal.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == imft_pkg::STAT_FULL || m_status == imft_pkg::STAT_NOT_FOUND)
        |-> m_slot == '0 && !m_refuse)
        else $error("failed add or remove reports a slot or a verdict");

endmodule

bind ipv4_mask_filter_table_top imft_checker u_imft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_refuse (m_refuse),
    .m_status (m_status),
    .m_slot   (m_slot)
);

`default_nettype wire
